### hdl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, held off during rst
`define ASSERT_IMPL(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk, held off during rst
`define ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

### hdl/cilvt_pkg.sv
// shared types and codes for the can id last value table
package cilvt_pkg;

  localparam int ID_W   = 29;
  localparam int PL_W   = 64;
  localparam int STAT_W = 2;
  localparam int SLOT_OUT_W  = 4;
  localparam int COUNT_OUT_W = 5;
  localparam int ADDR_MAX_W  = 8;

  localparam logic [STAT_W-1:0] STAT_UPDATED  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MISS,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                  id_en;
    logic                  pl_en;
    logic [ADDR_MAX_W-1:0] addr;
    logic [ID_W-1:0]       id;
    logic [PL_W-1:0]       pl;
  } mem_wr_t;

endpackage

### hdl/can_id_last_value_table_top.sv
// top level of the can id last value table
//
// in channel: in_valid/in_ready carry one request (can_id, payload).
// out channel: out_valid/out_ready carry one result (status, slot, entry_count).
// every request gives exactly one result.
// the identifier is compared against the filled slots one per cycle through
// a single comparator fed by the registered read port of the identifier ram.
// a request passes an accept state, then a scan state that checks the filled
// slots up to the first match (no scan when the table is empty), a decide
// state on a miss and a state that loads the result register.
// in_ready is high only while the sequencer is idle; a finished result waits
// in the output register so the next request can be taken and scanned, and
// the sequencer holds before its own result load while out_ready stays low.
// reset (rst, synchronous) empties the table by clearing the fill count;
// slot contents are not cleared and are only read below the fill count.
module can_id_last_value_table_top import cilvt_pkg::*; #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ID_W-1:0]        can_id,
  input  logic [PL_W-1:0]        payload,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STAT_W-1:0]      status,
  output logic [SLOT_OUT_W-1:0]  slot,
  output logic [COUNT_OUT_W-1:0] entry_count
);

  localparam int SLOT_W = $clog2((TABLE_SLOTS > 1) ? TABLE_SLOTS : 2);

  mem_wr_t           wr;
  logic [SLOT_W-1:0] rd_addr;
  logic [ID_W-1:0]   rd_id;

  cilvt_ctrl #(.SLOTS(TABLE_SLOTS)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .can_id      (can_id),
    .payload     (payload),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .slot        (slot),
    .entry_count (entry_count),
    .wr          (wr),
    .rd_addr     (rd_addr),
    .rd_id       (rd_id)
  );

  cilvt_mem #(.SLOTS(TABLE_SLOTS)) u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_id   (rd_id)
  );

endmodule

### hdl/cilvt_mem.sv
// identifier and payload storage with a registered identifier read port
module cilvt_mem import cilvt_pkg::*; #(
  parameter int SLOTS = 16,
  localparam int SLOT_W = $clog2((SLOTS > 1) ? SLOTS : 2)
) (
  input  logic              clk,
  input  mem_wr_t           wr,
  input  logic [SLOT_W-1:0] rd_addr,
  output logic [ID_W-1:0]   rd_id
);

  logic [ID_W-1:0] id_mem [SLOTS];
  logic [PL_W-1:0] pl_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.id_en) begin
      id_mem[wr.addr[SLOT_W-1:0]] <= wr.id;
    end
    if (wr.pl_en) begin
      pl_mem[wr.addr[SLOT_W-1:0]] <= wr.pl;
    end
    rd_id <= id_mem[rd_addr];
  end

endmodule

### hdl/cilvt_ctrl.sv
// scan sequencer with the shared identifier compare and the result register
module cilvt_ctrl import cilvt_pkg::*; #(
  parameter int SLOTS = 16,
  localparam int SLOT_W = $clog2((SLOTS > 1) ? SLOTS : 2),
  localparam int CNT_W  = $clog2(SLOTS + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ID_W-1:0]        can_id,
  input  logic [PL_W-1:0]        payload,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STAT_W-1:0]      status,
  output logic [SLOT_OUT_W-1:0]  slot,
  output logic [COUNT_OUT_W-1:0] entry_count,
  output mem_wr_t                wr,
  output logic [SLOT_W-1:0]      rd_addr,
  input  logic [ID_W-1:0]        rd_id
);

  localparam logic [CNT_W:0] SLOTS_C = (CNT_W + 1)'(SLOTS);

  state_t            state, state_next;
  logic [ID_W-1:0]   id_r;
  logic [PL_W-1:0]   pl_r;
  logic [SLOT_W-1:0] scan_idx;
  logic [CNT_W-1:0]  fill;
  logic [STAT_W-1:0] res_status;
  logic [SLOT_W-1:0] res_slot;
  logic              hit;
  logic              last;
  logic              room;
  logic              out_free;
  logic [31:0]       slot_ext;
  logic [31:0]       cnt_ext;

  assign hit      = (rd_id == id_r);
  assign last     = ((CNT_W + 1)'(scan_idx) + 1'b1) == (CNT_W + 1)'(fill);
  assign room     = (CNT_W + 1)'(fill) < SLOTS_C;
  assign out_free = !out_valid || out_ready;
  assign slot_ext = 32'(res_slot);
  assign cnt_ext  = 32'(fill);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rd_addr    = scan_idx + 1'b1;
    wr         = '0;
    wr.id      = id_r;
    wr.pl      = pl_r;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        rd_addr  = '0;
        if (in_valid) begin
          state_next = (fill == '0) ? ST_MISS : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          wr.pl_en   = 1'b1;
          wr.addr    = ADDR_MAX_W'(scan_idx);
          state_next = ST_DONE;
        end else if (last) begin
          state_next = ST_MISS;
        end
      end
      ST_MISS: begin
        if (room) begin
          wr.id_en = 1'b1;
          wr.pl_en = 1'b1;
          wr.addr  = ADDR_MAX_W'(fill[SLOT_W-1:0]);
        end
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if ((state == ST_MISS) && room) begin
        fill <= fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        id_r     <= can_id;
        pl_r     <= payload;
        scan_idx <= '0;
      end
      ST_SCAN: begin
        scan_idx <= scan_idx + 1'b1;
        if (hit) begin
          res_status <= STAT_UPDATED;
          res_slot   <= scan_idx;
        end
      end
      ST_MISS: begin
        if (room) begin
          res_status <= STAT_INSERTED;
          res_slot   <= fill[SLOT_W-1:0];
        end else begin
          res_status <= STAT_FULL;
          res_slot   <= '0;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          status      <= res_status;
          slot        <= slot_ext[SLOT_OUT_W-1:0];
          entry_count <= cnt_ext[COUNT_OUT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### hdl/cilvt_checker.sv
// port level checks for the can id last value table and their bind
`include "assert_macros.svh"

module cilvt_checker import cilvt_pkg::*; #(
  parameter int SLOTS = 16
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic [ID_W-1:0]        can_id,
  input logic [PL_W-1:0]        payload,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [STAT_W-1:0]      status,
  input logic [SLOT_OUT_W-1:0]  slot,
  input logic [COUNT_OUT_W-1:0] entry_count
);

  localparam logic [31:0] SLOTS_C = 32'(SLOTS);

  logic in_fire;
  logic res_full;

  assign in_fire  = in_valid && in_ready;
  assign res_full = out_valid && (status == STAT_FULL);

  // result held while stalled
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(status) && $stable(slot) && $stable(entry_count))
  // busy in the cycle after a request is taken
  `ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready)
  // full result reports slot zero and a full table
  `ASSERT_IMPL(a_full_shape, res_full,
    (slot == '0) && (entry_count == SLOTS_C[COUNT_OUT_W-1:0]))
  // no undefined status code
  `ASSERT_IMPL(a_status_code, out_valid,
    (status == STAT_UPDATED) || (status == STAT_INSERTED) || (status == STAT_FULL))
  // an inserted entry leaves the table nonempty
  `ASSERT_IMPL(a_insert_count, out_valid && (status == STAT_INSERTED),
    entry_count != '0)

  logic unused_payload;
  assign unused_payload = ^{can_id, payload};

endmodule

bind can_id_last_value_table_top cilvt_checker #(.SLOTS(TABLE_SLOTS)) u_cilvt_checker (.*);

### sim/tb_can_id_last_value_table_top.sv
// testbench for the can id last value table: directed and random frames checked by a scoreboard
module tb_can_id_last_value_table_top import cilvt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam int RANDOM_FRAMES = 1550;

  typedef struct packed {
    logic [STAT_W-1:0]      status;
    logic [SLOT_OUT_W-1:0]  slot;
    logic [COUNT_OUT_W-1:0] entries;
  } table_reply_t;

  class frame_table_board;
    logic [ID_W-1:0] known_ids[SLOTS];
    logic [PL_W-1:0] known_payloads[SLOTS];
    int unsigned     filled;
    table_reply_t    expected_replies[$];
    int unsigned     errors;
    int unsigned     frames;
    int unsigned     updates;
    int unsigned     inserts;
    int unsigned     fulls;

    function new();
      filled = 0;
      errors = 0;
      frames = 0;
      updates = 0;
      inserts = 0;
      fulls = 0;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function void note_frame(logic [ID_W-1:0] id, logic [PL_W-1:0] data);
      table_reply_t r;
      int hit;
      hit = -1;
      for (int i = 0; i < int'(filled); i++) begin
        if (hit < 0 && known_ids[i] == id) hit = i;
      end
      if (hit >= 0) begin
        known_payloads[hit] = data;
        r.status = STAT_UPDATED;
        r.slot = SLOT_OUT_W'(hit);
        updates++;
      end else if (filled < SLOTS) begin
        known_ids[filled] = id;
        known_payloads[filled] = data;
        r.status = STAT_INSERTED;
        r.slot = SLOT_OUT_W'(filled);
        filled++;
        inserts++;
      end else begin
        r.status = STAT_FULL;
        r.slot = '0;
        fulls++;
      end
      r.entries = COUNT_OUT_W'(filled);
      frames++;
      expected_replies.push_back(r);
    endfunction

    function void check_result(logic [STAT_W-1:0] st, logic [SLOT_OUT_W-1:0] sl,
                               logic [COUNT_OUT_W-1:0] cnt);
      table_reply_t r;
      if (expected_replies.size() == 0) begin
        $display("%0t: result with no request waiting (status %0d slot %0d count %0d)",
                 $time, st, sl, cnt);
        errors++;
        return;
      end
      r = expected_replies.pop_front();
      if (st !== r.status) begin
        $display("%0t: status mismatch, expected %0d, got %0d", $time, r.status, st);
        errors++;
      end
      if (sl !== r.slot) begin
        $display("%0t: slot mismatch, expected %0d, got %0d", $time, r.slot, sl);
        errors++;
      end
      if (cnt !== r.entries) begin
        $display("%0t: entry_count mismatch, expected %0d, got %0d", $time, r.entries, cnt);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [ID_W-1:0]        can_id = '0;
  logic [PL_W-1:0]        payload = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [STAT_W-1:0]      status;
  logic [SLOT_OUT_W-1:0]  slot;
  logic [COUNT_OUT_W-1:0] entry_count;

  frame_table_board sb = new();
  int unsigned burst_left = 0;
  logic [15:0] stall_cyc = '0;

  can_id_last_value_table_top #(.TABLE_SLOTS(SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .can_id(can_id),
    .payload(payload),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .slot(slot),
    .entry_count(entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_frame(can_id, payload);
    if (!rst && out_valid && out_ready) sb.check_result(status, slot, entry_count);
  end

  // receiver stall pattern cycles through four modes
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 16'd1;
    case (stall_cyc[9:8])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= (stall_cyc[2:0] == 3'd0);
      default: out_ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  function automatic logic [PL_W-1:0] pick_payload();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_frame(input logic [ID_W-1:0] id, input logic [PL_W-1:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    can_id <= id;
    payload <= data;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [ID_W-1:0] id;
    int choice;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // id zero on an empty table must insert, not match an unwritten slot
    send_frame('0, '0);
    send_frame('1, '1);
    send_frame('0, 64'hA5A5_5A5A_F00F_0FF0);
    send_frame(29'h7FF, pick_payload());
    for (int k = 3; k < SLOTS; k++) send_frame({4'(k), 25'(k * 3 + 7)}, pick_payload());
    send_frame(29'h0000_0800, '1);
    send_frame(29'h1FFF_FFFE, '0);
    send_frame({4'(SLOTS - 1), 25'((SLOTS - 1) * 3 + 7)}, pick_payload());
    send_frame('1, '0);
    send_frame('0, '1);
    send_frame(29'h7FF, pick_payload());

    for (int n = 0; n < RANDOM_FRAMES; n++) begin
      if (n == RANDOM_FRAMES / 2) drain_replies();
      choice = $urandom_range(0, 19);
      id = sb.known_ids[$urandom_range(0, sb.filled - 1)];
      if (choice >= 17) id = id ^ (29'd1 << $urandom_range(0, ID_W - 1));
      else if (choice >= 12) id = ID_W'($urandom);
      send_frame(id, pick_payload());
    end

    drain_replies();
    repeat (25) @(posedge clk);
    $display("ran %0d frames through a %0d-slot table, leftover expectations: %0d",
             sb.frames, SLOTS, sb.pending());
    $display("replies: %0d updates, %0d inserts, %0d table full", sb.updates, sb.inserts,
             sb.fulls);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d replies outstanding", sb.pending());
    $display("FAIL");
    $finish;
  end
endmodule
